/* sv/masked_key_binary_heap_macros.svh */
// assertion macros for the masked key binary heap
`ifndef MASKED_KEY_BINARY_HEAP_MACROS_SVH
`define MASKED_KEY_BINARY_HEAP_MACROS_SVH
`ifndef SYNTHESIS
`define MKBH_ASSERT(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define MKBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);
`else
`define MKBH_ASSERT(label, clk, rst_n, prop, msg)
`define MKBH_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif
`endif

/* sv/mkbh_pkg.sv */
// ----------------------------------------------------------------------------
// mkbh_pkg
// types and codes shared by the masked key binary heap modules
// ----------------------------------------------------------------------------
`default_nettype none
package mkbh_pkg;
	localparam logic [1:0] REQ_INSERT = 2'd0;
	localparam logic [1:0] REQ_REMOVE_POS = 2'd1;
	localparam logic [1:0] REQ_REMOVE_COORD = 2'd2;

	localparam logic CFG_ORDER_MAX = 1'b0;
	localparam logic CFG_KEY_MASK = 1'b1;

	typedef struct packed {
		logic [1:0] req_type;
		logic signed [15:0] coord_x;
		logic signed [15:0] coord_y;
		logic signed [15:0] coord_z;
		logic [15:0] entry_flags;
		logic [6:0] position;
	} req_t;

	typedef struct packed {
		logic ok;
		logic [6:0] final_position;
		logic signed [15:0] out_x;
		logic signed [15:0] out_y;
		logic signed [15:0] out_z;
		logic [15:0] out_flags;
		logic [6:0] entry_count;
	} rsp_t;

	typedef struct packed {
		logic [15:0] x;
		logic [15:0] y;
		logic [15:0] z;
		logic [15:0] flags;
	} entry_t;

	// a strictly better than b under mask and order
	function automatic logic better(input logic [15:0] a, input logic [15:0] b,
		input logic [15:0] mask, input logic order_max);
		logic [15:0] ka;
		logic [15:0] kb;
		ka = a & mask;
		kb = b & mask;
		better = order_max ? (ka > kb) : (ka < kb);
	endfunction
endpackage
`default_nettype wire

/* sv/mkbh_ram.sv */
// ----------------------------------------------------------------------------
// mkbh_ram
// generic single write port ram with one registered read port
// ----------------------------------------------------------------------------
`default_nettype none
module mkbh_ram #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 64
) (
	input wire logic clk,
	input wire logic we,
	input wire logic [$clog2(DEPTH)-1:0] waddr,
	input wire logic [WIDTH-1:0] wdata,
	input wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0] rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	// write and registered read
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* sv/masked_key_binary_heap.sv */
// ----------------------------------------------------------------------------
// masked_key_binary_heap
// binary heap of coordinate entries keyed by a masked flag word
// ----------------------------------------------------------------------------
// Usage: pulse start with req for one cycle while busy is low. The block
// raises busy, walks the heap in its entry ram and presents one rsp item
// with done high for exactly one cycle, then drops busy. The receiver
// cannot stall; rsp is only valid while done is high.
// Each step issues one ram read and at most one write. An insert moves
// the new entry up level by level; a remove at position moves the last
// entry into the hole, then up and down level by level (no moves when
// the last entry itself is removed); a remove by coordinate first
// searches the entries in order and, on a match, removes as at position.
// A full, bad or unused request goes straight to done. A new item is
// taken only once busy has dropped after done; the registered ram read
// sets each step.
// Configuration (order_max, key_mask) is written through cfg_we, cfg_index
// and cfg_data; the user must do so only while idle (the block does not
// enforce it), and it then takes effect on the next item.
// Reset clears the count and config; ram contents are left undefined
// since only entries at positions 1 to the count are ever used.
// ----------------------------------------------------------------------------
`default_nettype none
`include "masked_key_binary_heap_macros.svh"
module masked_key_binary_heap #(
	parameter int CAPACITY = 64
) (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic start,
	input wire mkbh_pkg::req_t req,
	output logic busy,
	output logic done,
	output mkbh_pkg::rsp_t rsp,
	input wire logic cfg_we,
	input wire logic cfg_index,
	input wire logic [15:0] cfg_data
);
	localparam int AW = $clog2(CAPACITY + 1);
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int RD = CAPACITY + 1;

	localparam logic [3:0] ST_IDLE = 4'd0;
	localparam logic [3:0] ST_SRCH = 4'd1;
	localparam logic [3:0] ST_SRCHW = 4'd2;
	localparam logic [3:0] ST_RDLAST = 4'd3;
	localparam logic [3:0] ST_RDP = 4'd4;
	localparam logic [3:0] ST_UPRD = 4'd5;
	localparam logic [3:0] ST_UPCMP = 4'd6;
	localparam logic [3:0] ST_DNL = 4'd7;
	localparam logic [3:0] ST_DNR = 4'd8;
	localparam logic [3:0] ST_DNCMP = 4'd9;
	localparam logic [3:0] ST_DONE = 4'd10;
	localparam logic [3:0] ST_RMV = 4'd11;

	logic [3:0] state_q;
	logic order_q;
	logic [15:0] mask_q;
	logic [CW-1:0] count_q;
	mkbh_pkg::req_t req_q;
	mkbh_pkg::entry_t cur_q;
	mkbh_pkg::entry_t best_q;
	logic [AW-1:0] pos_q;
	logic [AW:0] best_pos_q;
	logic [CW-1:0] idx_q;
	logic is_ins_q;
	mkbh_pkg::rsp_t rsp_q;

	logic we;
	logic [AW-1:0] waddr;
	mkbh_pkg::entry_t wdata;
	logic [AW-1:0] raddr;
	mkbh_pkg::entry_t rdata;

	mkbh_ram #(.WIDTH(64), .DEPTH(RD)) u_ram (
		.clk(clk), .we(we), .waddr(waddr), .wdata(wdata),
		.raddr(raddr), .rdata(rdata)
	);

	logic [AW:0] lchild;
	logic [AW:0] rchild;
	logic dn_right_win;
	assign lchild = {pos_q, 1'b0};
	assign rchild = lchild + (AW+1)'(1);

	// right child beats the best of current and left child
	assign dn_right_win = (rchild <= (AW+1)'(count_q)) &&
		mkbh_pkg::better(rdata.flags, best_q.flags, mask_q, order_q);

	// ram port control
	always_comb begin
		we = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		raddr = pos_q;
		unique case (state_q)
			ST_IDLE: begin
				raddr = AW'(1);
			end
			ST_SRCH: begin
				raddr = idx_q[AW-1:0];
			end
			ST_SRCHW: begin
				raddr = idx_q[AW-1:0];
			end
			ST_RDLAST: begin
				raddr = count_q[AW-1:0];
			end
			ST_RDP: begin
				raddr = pos_q;
			end
			ST_UPRD: begin
				raddr = pos_q >> 1;
			end
			ST_UPCMP: begin
				// parent moves down when current is better
				if (pos_q > AW'(1) && mkbh_pkg::better(cur_q.flags, rdata.flags,
						mask_q, order_q)) begin
					we = 1'b1;
					waddr = pos_q;
					wdata = rdata;
				end else begin
					we = 1'b1;
					wdata = cur_q;
				end
			end
			ST_DNL: begin
				raddr = lchild[AW-1:0];
			end
			ST_DNR: begin
				raddr = AW'(lchild + (AW+1)'(1));
			end
			ST_DNCMP: begin
				// winning child moves up, or current settles here
				we = 1'b1;
				waddr = pos_q;
				if (dn_right_win) begin
					wdata = rdata;
				end else if (best_pos_q != {1'b0, pos_q}) begin
					wdata = best_q;
				end else begin
					wdata = cur_q;
				end
			end
			ST_RMV: begin
				raddr = pos_q;
			end
			ST_DONE: begin
			end
			default: begin
			end
		endcase
	end

	// config registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			order_q <= 1'b0;
			mask_q <= 16'hFFFF;
		end else if (cfg_we) begin
			if (cfg_index == mkbh_pkg::CFG_ORDER_MAX) begin
				order_q <= cfg_data[0];
			end else begin
				mask_q <= cfg_data;
			end
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			count_q <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (start) begin
						req_q <= req;
						rsp_q <= '0;
						is_ins_q <= (req.req_type == mkbh_pkg::REQ_INSERT);
						unique case (req.req_type)
							mkbh_pkg::REQ_INSERT: begin
								if (count_q < CW'(CAPACITY)) begin
									count_q <= count_q + CW'(1);
									pos_q <= AW'(count_q + CW'(1));
									cur_q <= '{x: req.coord_x, y: req.coord_y,
										z: req.coord_z, flags: req.entry_flags};
									state_q <= ST_UPRD;
								end else begin
									state_q <= ST_DONE;
								end
							end
							mkbh_pkg::REQ_REMOVE_POS: begin
								if (req.position != 7'd0 &&
										{{CW{1'b0}}, req.position} <=
										{7'd0, count_q}) begin
									pos_q <= AW'(req.position);
									state_q <= ST_RMV;
								end else begin
									state_q <= ST_DONE;
								end
							end
							mkbh_pkg::REQ_REMOVE_COORD: begin
								idx_q <= CW'(1);
								state_q <= (count_q == '0) ? ST_DONE : ST_SRCHW;
							end
							default: begin
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_RMV: begin
					state_q <= ST_SRCH;
					idx_q <= CW'(pos_q);
				end
				ST_SRCHW: begin
					state_q <= ST_SRCH;
				end
				ST_SRCH: begin
					// rdata holds entry idx_q (or the position for remove at)
					if (req_q.req_type == mkbh_pkg::REQ_REMOVE_POS) begin
						rsp_q.ok <= 1'b1;
						rsp_q.out_x <= rdata.x;
						rsp_q.out_y <= rdata.y;
						rsp_q.out_z <= rdata.z;
						rsp_q.out_flags <= rdata.flags;
						pos_q <= idx_q[AW-1:0];
						state_q <= ST_RDLAST;
					end else if (rdata.x == req_q.coord_x && rdata.y == req_q.coord_y
							&& rdata.z == req_q.coord_z) begin
						rsp_q.ok <= 1'b1;
						pos_q <= idx_q[AW-1:0];
						state_q <= ST_RDLAST;
					end else if (idx_q == count_q) begin
						state_q <= ST_DONE;
					end else begin
						idx_q <= idx_q + CW'(1);
						state_q <= ST_SRCHW;
					end
				end
				ST_RDLAST: begin
					count_q <= count_q - CW'(1);
					state_q <= ST_RDP;
				end
				ST_RDP: begin
					// rdata is the last entry, now moved into the hole
					cur_q <= rdata;
					state_q <= (CW'(pos_q) <= count_q) ? ST_UPRD : ST_DONE;
				end
				ST_UPRD: begin
					state_q <= ST_UPCMP;
				end
				ST_UPCMP: begin
					if (pos_q > AW'(1) && mkbh_pkg::better(cur_q.flags, rdata.flags,
							mask_q, order_q)) begin
						pos_q <= pos_q >> 1;
						state_q <= ST_UPRD;
					end else if (is_ins_q) begin
						rsp_q.ok <= 1'b1;
						rsp_q.final_position <= 7'(pos_q);
						state_q <= ST_DONE;
					end else begin
						best_q <= cur_q;
						best_pos_q <= {1'b0, pos_q};
						state_q <= ST_DNL;
					end
				end
				ST_DNL: begin
					best_q <= cur_q;
					best_pos_q <= {1'b0, pos_q};
					state_q <= ST_DNR;
				end
				ST_DNR: begin
					// rdata is the left child
					if (lchild <= (AW+1)'(count_q) &&
							mkbh_pkg::better(rdata.flags, cur_q.flags, mask_q, order_q)) begin
						best_q <= rdata;
						best_pos_q <= lchild;
					end
					state_q <= ST_DNCMP;
				end
				ST_DNCMP: begin
					// rdata is the right child; follow the hole down
					if (dn_right_win) begin
						pos_q <= rchild[AW-1:0];
						state_q <= ST_DNL;
					end else if (best_pos_q != {1'b0, pos_q}) begin
						pos_q <= best_pos_q[AW-1:0];
						state_q <= ST_DNL;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	assign busy = (state_q != ST_IDLE);
	assign done = (state_q == ST_DONE);

	// response with the current entry count
	always_comb begin
		rsp = rsp_q;
		rsp.entry_count = 7'(count_q);
	end

	`MKBH_ASSERT_NEXT(a_done_one, clk, arst_n, done, !done, "done held two cycles")
	`MKBH_ASSERT(a_count_cap, clk, arst_n, (count_q <= CW'(CAPACITY)), "count over capacity")
	`MKBH_ASSERT_NEXT(a_start_busy, clk, arst_n, (start && !busy), busy, "start not taken")
endmodule
`default_nettype wire

/* sim/tb.sv */
// ----------------------------------------------------------------------------
// tb
// self-checking testbench for the masked key binary heap: a local heap
// model predicts every response, a monitor compares each done item
// ----------------------------------------------------------------------------
`default_nettype none
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAP = 64;
	localparam int STALL_LIMIT = 20000;
	localparam logic [1:0] REQ_UNUSED = 2'd3;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	mkbh_pkg::req_t req = '0;
	logic busy;
	logic done;
	mkbh_pkg::rsp_t rsp;
	logic cfg_we = 1'b0;
	logic cfg_index = 1'b0;
	logic [15:0] cfg_data = '0;

	// model state
	mkbh_pkg::entry_t heap_model [1:CAP];
	int model_count = 0;
	logic model_max = 1'b0;
	logic [15:0] model_mask = 16'hFFFF;

	mkbh_pkg::rsp_t expected_rsp_q [$];
	int errors = 0;
	int idle_cycles = 0;
	int items_sent = 0;
	int inserts_sent = 0;
	int removes_sent = 0;
	int coord_removes_sent = 0;
	bit allow_gaps = 1'b1;
	// small coordinate pool so coordinate matches happen often
	logic [15:0] coord_pool [0:7];

	masked_key_binary_heap #(.CAPACITY(CAP)) DUT (
		.clk(clk), .arst_n(arst_n), .start(start), .req(req), .busy(busy),
		.done(done), .rsp(rsp), .cfg_we(cfg_we), .cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	always #2 clk = ~clk;

	function automatic bit key_better(input int a, input int b);
		logic [15:0] ka;
		logic [15:0] kb;
		ka = heap_model[a].flags & model_mask;
		kb = heap_model[b].flags & model_mask;
		return model_max ? (ka > kb) : (ka < kb);
	endfunction

	function automatic void swap_entries(input int a, input int b);
		mkbh_pkg::entry_t t;
		t = heap_model[a];
		heap_model[a] = heap_model[b];
		heap_model[b] = t;
	endfunction

	function automatic int bubble_up(input int p);
		while (p > 1 && key_better(p, p / 2)) begin
			swap_entries(p, p / 2);
			p = p / 2;
		end
		return p;
	endfunction

	function automatic void bubble_down(input int p);
		int best;
		forever begin
			best = p;
			if (2 * p <= model_count && key_better(2 * p, best)) best = 2 * p;
			if (2 * p + 1 <= model_count && key_better(2 * p + 1, best)) best = 2 * p + 1;
			if (best == p) break;
			swap_entries(p, best);
			p = best;
		end
	endfunction

	function automatic void take_out(input int p);
		heap_model[p] = heap_model[model_count];
		model_count--;
		if (p <= model_count) begin
			p = bubble_up(p);
			bubble_down(p);
		end
	endfunction

	// predicted response of the heap for one request
	function automatic mkbh_pkg::rsp_t heap_response(input mkbh_pkg::req_t r);
		mkbh_pkg::rsp_t o;
		o = '0;
		case (r.req_type)
			mkbh_pkg::REQ_INSERT: begin
				if (model_count < CAP) begin
					model_count++;
					heap_model[model_count] = {r.coord_x, r.coord_y, r.coord_z, r.entry_flags};
					o.final_position = 7'(bubble_up(model_count));
					o.ok = 1'b1;
				end
			end
			mkbh_pkg::REQ_REMOVE_POS: begin
				if (r.position >= 1 && r.position <= model_count) begin
					{o.out_x, o.out_y, o.out_z, o.out_flags} = heap_model[r.position];
					take_out(r.position);
					o.ok = 1'b1;
				end
			end
			mkbh_pkg::REQ_REMOVE_COORD: begin
				for (int i = 1; i <= model_count; i++) begin
					if (heap_model[i].x == r.coord_x && heap_model[i].y == r.coord_y &&
						heap_model[i].z == r.coord_z) begin
						take_out(i);
						o.ok = 1'b1;
						break;
					end
				end
			end
			default: ;
		endcase
		o.entry_count = 7'(model_count);
		return o;
	endfunction

	// response checker
	always @(posedge clk) begin
		mkbh_pkg::rsp_t e;
		if (arst_n && done) begin
			if (expected_rsp_q.size() == 0) begin
				$error("response with no request outstanding");
				errors++;
			end else begin
				e = expected_rsp_q.pop_front();
				if (rsp.ok !== e.ok) begin
					$error("ok exp %0d got %0d", e.ok, rsp.ok); errors++;
				end
				if (rsp.final_position !== e.final_position) begin
					$error("final_position exp %0d got %0d", e.final_position,
						rsp.final_position);
					errors++;
				end
				if (rsp.out_x !== e.out_x) begin
					$error("out_x exp %0d got %0d", e.out_x, rsp.out_x); errors++;
				end
				if (rsp.out_y !== e.out_y) begin
					$error("out_y exp %0d got %0d", e.out_y, rsp.out_y); errors++;
				end
				if (rsp.out_z !== e.out_z) begin
					$error("out_z exp %0d got %0d", e.out_z, rsp.out_z); errors++;
				end
				if (rsp.out_flags !== e.out_flags) begin
					$error("out_flags exp %h got %h", e.out_flags, rsp.out_flags); errors++;
				end
				if (rsp.entry_count !== e.entry_count) begin
					$error("entry_count exp %0d got %0d", e.entry_count, rsp.entry_count);
					errors++;
				end
			end
		end
	end

	// watchdog on cycles with no item moving
	always @(posedge clk) begin
		if ((start && !busy) || done || !arst_n) idle_cycles <= 0;
		else if (idle_cycles >= STALL_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else idle_cycles <= idle_cycles + 1;
	end

	// start stays high after an accept until the next item or a drain
	task automatic send_item(input mkbh_pkg::req_t r);
		int gap;
		if (allow_gaps && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 14);
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		req <= r;
		@(posedge clk);
		while (busy) @(posedge clk);
		expected_rsp_q.push_back(heap_response(r));
		items_sent++;
		case (r.req_type)
			mkbh_pkg::REQ_INSERT: inserts_sent++;
			mkbh_pkg::REQ_REMOVE_POS: removes_sent++;
			mkbh_pkg::REQ_REMOVE_COORD: coord_removes_sent++;
			default: ;
		endcase
	endtask

	task automatic wait_drain();
		start <= 1'b0;
		while (expected_rsp_q.size() != 0) @(posedge clk);
		repeat (120) @(posedge clk);
	endtask

	task automatic write_reg(input logic idx, input logic [15:0] val);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == mkbh_pkg::CFG_ORDER_MAX) model_max = val[0];
		else model_mask = val;
		@(posedge clk);
	endtask

	function automatic mkbh_pkg::req_t make_req(input logic [1:0] t, input logic [15:0] x,
		input logic [15:0] y, input logic [15:0] z, input logic [15:0] f,
		input logic [6:0] p);
		mkbh_pkg::req_t r;
		r.req_type = t;
		r.coord_x = x;
		r.coord_y = y;
		r.coord_z = z;
		r.entry_flags = f;
		r.position = p;
		return r;
	endfunction

	function automatic mkbh_pkg::req_t rand_req(input int ins_weight);
		mkbh_pkg::req_t r;
		int k;
		r = make_req(mkbh_pkg::REQ_INSERT, coord_pool[$urandom_range(0, 7)],
			coord_pool[$urandom_range(0, 7)], coord_pool[$urandom_range(0, 7)],
			16'($urandom), 7'($urandom_range(1, model_count + 2)));
		if ($urandom_range(0, 9) == 0) begin
			r.coord_x = 16'($urandom);
			r.coord_y = 16'($urandom);
			r.coord_z = 16'($urandom);
			r.position = 7'($urandom);
		end
		k = $urandom_range(0, 99);
		if (k < ins_weight) r.req_type = mkbh_pkg::REQ_INSERT;
		else if (k < ins_weight + (100 - ins_weight) / 2) r.req_type = mkbh_pkg::REQ_REMOVE_POS;
		else if (k < 98) r.req_type = mkbh_pkg::REQ_REMOVE_COORD;
		else r.req_type = REQ_UNUSED;
		if (r.req_type == mkbh_pkg::REQ_REMOVE_COORD && model_count > 0 &&
				$urandom_range(0, 1)) begin
			k = $urandom_range(1, model_count);
			r.coord_x = heap_model[k].x;
			r.coord_y = heap_model[k].y;
			r.coord_z = heap_model[k].z;
		end
		return r;
	endfunction

	// extremes of the fields, each request kind and the special cases
	task automatic test_directed();
		send_item(make_req(mkbh_pkg::REQ_REMOVE_POS, '0, '0, '0, '0, 7'd1));
		send_item(make_req(mkbh_pkg::REQ_REMOVE_COORD, '0, '0, '0, '0, 7'd0));
		send_item(make_req(mkbh_pkg::REQ_INSERT, 16'h8000, 16'h7FFF, 16'hFFFF, 16'hFFFF,
			7'h7F));
		send_item(make_req(mkbh_pkg::REQ_INSERT, 16'h7FFF, 16'h8000, 16'h0000, 16'h0000,
			7'd0));
		send_item(make_req(mkbh_pkg::REQ_INSERT, 16'h1234, 16'h0001, 16'h0002, 16'h00FF,
			7'd64));
		send_item(make_req(mkbh_pkg::REQ_INSERT, 16'h1234, 16'h0001, 16'h0002, 16'h00FF,
			7'd64));
		send_item(make_req(mkbh_pkg::REQ_REMOVE_POS, '0, '0, '0, '0, 7'd0));
		send_item(make_req(mkbh_pkg::REQ_REMOVE_POS, '0, '0, '0, '0, 7'd5));
		send_item(make_req(mkbh_pkg::REQ_REMOVE_POS, '0, '0, '0, '0, 7'h7F));
		send_item(make_req(REQ_UNUSED, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 7'h7F));
		send_item(make_req(mkbh_pkg::REQ_REMOVE_COORD, 16'h1234, 16'h0001, 16'h0002,
			'0, '0));
		send_item(make_req(mkbh_pkg::REQ_REMOVE_COORD, 16'h5555, 16'h0001, 16'h0002,
			'0, '0));
		send_item(make_req(mkbh_pkg::REQ_REMOVE_POS, '0, '0, '0, '0, 7'd4));
		send_item(make_req(mkbh_pkg::REQ_REMOVE_POS, '0, '0, '0, '0, 7'd3));
		send_item(make_req(mkbh_pkg::REQ_REMOVE_POS, '0, '0, '0, '0, 7'd1));
		send_item(make_req(mkbh_pkg::REQ_REMOVE_POS, '0, '0, '0, '0, 7'd1));
		wait_drain();
	endtask

	// fill past capacity so the full case shows, then drain by position
	task automatic test_fill_and_drain();
		repeat (CAP + 3)
			send_item(make_req(mkbh_pkg::REQ_INSERT, 16'($urandom), 16'($urandom),
				16'($urandom), 16'($urandom), 7'($urandom)));
		while (model_count > 0)
			send_item(make_req(mkbh_pkg::REQ_REMOVE_POS, '0, '0, '0, '0,
				7'($urandom_range(1, model_count))));
		wait_drain();
	endtask

	// mixed traffic under one order and mask setting
	task automatic test_random_mix(input logic ord, input logic [15:0] mask, input int n);
		write_reg(mkbh_pkg::CFG_ORDER_MAX, {15'd0, ord});
		write_reg(mkbh_pkg::CFG_KEY_MASK, mask);
		for (int i = 0; i < n; i++)
			send_item(rand_req(model_count < 8 ? 70 : (model_count > 56 ? 30 : 50)));
		wait_drain();
	endtask

	initial begin
		for (int i = 0; i < 8; i++) coord_pool[i] = 16'($urandom);
		coord_pool[0] = 16'h8000;
		coord_pool[1] = 16'h7FFF;
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_directed();
		test_fill_and_drain();
		test_random_mix(1'b1, 16'hFFFF, 300);
		test_random_mix(1'b0, 16'h0000, 250);
		test_random_mix(1'b1, 16'h00F0, 300);
		test_random_mix(1'b0, 16'($urandom), 300);
		test_random_mix(1'b1, 16'($urandom), 250);
		allow_gaps = 1'b0;
		test_random_mix(1'b0, 16'hFFFF, 300);
		$display("covered %0d items: %0d inserts, %0d removes by position, %0d by coordinate",
			items_sent, inserts_sent, removes_sent, coord_removes_sent);
		$display("both orders and several key masks, including all-ones and zero");
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end
endmodule
`default_nettype wire

/* files.f */
+incdir+sv
sv/mkbh_pkg.sv
sv/mkbh_ram.sv
sv/masked_key_binary_heap.sv
sim/tb.sv
